// File: hw/rtl/lsh_pkg.sv
// Shared types and constants for the LTP segment header parser.
`default_nettype none

package lsh_pkg;

  // Default SDNV field widths.
  localparam int ORIGINATOR_BITS_DEF = 64;
  localparam int NUMBER_BITS_DEF     = 32;

  // SDNV and header layout constants.
  localparam int          GROUP_BITS  = 7;
  localparam int          NIBBLE_BITS = 4;
  localparam logic [3:0]  NIBBLE_MASK = 4'hF;
  localparam logic [4:0]  COUNT_MAX   = 5'd31;
  localparam logic [4:0]  COUNT_FIRST = 5'd1;

  // Position of the header byte that is expected next.
  typedef enum logic [3:0] {
    PH_CONTROL = 4'b0001,
    PH_ORIG    = 4'b0010,
    PH_NUM     = 4'b0100,
    PH_EXT     = 4'b1000
  } phase_t;

  // One incoming header byte.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       restart;
  } in_item_t;

  // One parsed header.
  typedef struct packed {
    logic [3:0]  version;
    logic [3:0]  segment_type;
    logic [63:0] originator;
    logic [31:0] session_number;
    logic [3:0]  header_ext_count;
    logic [3:0]  trailer_ext_count;
    logic [4:0]  header_length;
    logic        overflow_error;
  } out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/lsh_sdnv_step.sv
// One SDNV decode step: shifts a 7-bit group into an accumulator and flags overflow.
`default_nettype none

module lsh_sdnv_step #(
  parameter int WIDTH = 64
) (
  input  wire logic [WIDTH-1:0]                 cur,
  input  wire logic [lsh_pkg::GROUP_BITS-1:0]   grp,
  output logic      [WIDTH-1:0]                 nxt,
  output logic                                  ovf
);

  // Bits shifted out of the top mean the value no longer fits.
  assign ovf = |cur[WIDTH-1:WIDTH-lsh_pkg::GROUP_BITS];

  // Keep the low bits and append the new group.
  assign nxt = {cur[WIDTH-lsh_pkg::GROUP_BITS-1:0], grp};

endmodule

`default_nettype wire

// File: hw/rtl/lsh_core.sv
// Header parse state machine: tracks the byte position and builds the result.
`default_nettype none

module lsh_core #(
  parameter int ORIGINATOR_BITS = lsh_pkg::ORIGINATOR_BITS_DEF,
  parameter int NUMBER_BITS     = lsh_pkg::NUMBER_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire lsh_pkg::in_item_t item,
  output logic                   emit,
  output lsh_pkg::out_item_t     result
);

  lsh_pkg::phase_t              phase_r, phase_nxt, phase_eff;
  logic [ORIGINATOR_BITS-1:0]   orig_acc_r, orig_acc_nxt, orig_step;
  logic [NUMBER_BITS-1:0]       num_acc_r, num_acc_nxt, num_step;
  logic [7:0]                   ctrl_r, ctrl_nxt;
  logic [4:0]                   count_r, count_nxt, count_inc;
  logic                         ovf_r, ovf_nxt;
  logic                         orig_ovf, num_ovf;
  logic [7:0]                   b;

  assign b = item.byte_value;

  // A restart forces this byte to be read as a control byte.
  assign phase_eff = item.restart ? lsh_pkg::PH_CONTROL : phase_r;
  assign emit      = (phase_eff == lsh_pkg::PH_EXT);

  // Byte count saturates at its maximum.
  assign count_inc = (count_r == lsh_pkg::COUNT_MAX) ? count_r : count_r + 5'd1;

  // SDNV decode steps for both fields.
  lsh_sdnv_step #(.WIDTH(ORIGINATOR_BITS)) u_orig_step (
    .cur (orig_acc_r),
    .grp (b[lsh_pkg::GROUP_BITS-1:0]),
    .nxt (orig_step),
    .ovf (orig_ovf)
  );

  lsh_sdnv_step #(.WIDTH(NUMBER_BITS)) u_num_step (
    .cur (num_acc_r),
    .grp (b[lsh_pkg::GROUP_BITS-1:0]),
    .nxt (num_step),
    .ovf (num_ovf)
  );

  // Next state for the current byte.
  always_comb begin
    phase_nxt    = phase_r;
    orig_acc_nxt = orig_acc_r;
    num_acc_nxt  = num_acc_r;
    ctrl_nxt     = ctrl_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    case (phase_eff)
      lsh_pkg::PH_CONTROL: begin
        ctrl_nxt     = b;
        orig_acc_nxt = '0;
        num_acc_nxt  = '0;
        ovf_nxt      = 1'b0;
        count_nxt    = lsh_pkg::COUNT_FIRST;
        phase_nxt    = lsh_pkg::PH_ORIG;
      end
      lsh_pkg::PH_ORIG: begin
        count_nxt    = count_inc;
        orig_acc_nxt = orig_step;
        ovf_nxt      = ovf_r | orig_ovf;
        if (!b[7]) begin
          phase_nxt = lsh_pkg::PH_NUM;
        end
      end
      lsh_pkg::PH_NUM: begin
        count_nxt   = count_inc;
        num_acc_nxt = num_step;
        ovf_nxt     = ovf_r | num_ovf;
        if (!b[7]) begin
          phase_nxt = lsh_pkg::PH_EXT;
        end
      end
      default: begin
        phase_nxt = lsh_pkg::PH_CONTROL;
      end
    endcase
  end

  // Control state is reset; the accumulators are cleared by every control byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lsh_pkg::PH_CONTROL;
      ctrl_r  <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      ctrl_r  <= ctrl_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      orig_acc_r <= orig_acc_nxt;
      num_acc_r  <= num_acc_nxt;
    end
  end

  // Result fields, valid when the extensions byte is processed.
  always_comb begin
    result.version           = ctrl_r[7:lsh_pkg::NIBBLE_BITS];
    result.segment_type      = ctrl_r[lsh_pkg::NIBBLE_BITS-1:0] & lsh_pkg::NIBBLE_MASK;
    result.originator        = 64'(orig_acc_r);
    result.session_number    = 32'(num_acc_r);
    result.header_ext_count  = b[7:lsh_pkg::NIBBLE_BITS];
    result.trailer_ext_count = b[lsh_pkg::NIBBLE_BITS-1:0] & lsh_pkg::NIBBLE_MASK;
    result.header_length     = count_inc;
    result.overflow_error    = ovf_r;
  end

endmodule

`default_nettype wire

// File: hw/rtl/ltp_segment_header_parser.sv
// Top level of the LTP segment header parser: input register, parser core, result register.
//
//  Channel | Ports                          | Direction | Carries
//  --------+--------------------------------+-----------+--------------------------
//  input   | in_valid, in_stall, in_item    | in        | one header byte per item
//  result  | out_valid, out_stall, out_item | out       | one parsed header per item
//
// One byte item is taken every cycle unless the input is stalled; the parser core updates
// its state between the input register and the result register.
// The result of an extensions byte is loaded into the result register when the byte
// leaves the input register, which waits while a full result register is stalled.
// Reset is synchronous and active low and returns the parser to expecting a control byte.
// A stalled result holds only bytes that would produce a new result; other bytes keep flowing.
`default_nettype none

module ltp_segment_header_parser #(
  parameter int ORIGINATOR_BITS = lsh_pkg::ORIGINATOR_BITS_DEF,
  parameter int NUMBER_BITS     = lsh_pkg::NUMBER_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire lsh_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output lsh_pkg::out_item_t      out_item
);

  logic                in_valid_r;
  lsh_pkg::in_item_t   in_item_r;
  logic                out_valid_r, out_valid_nxt;
  lsh_pkg::out_item_t  out_item_r;
  lsh_pkg::out_item_t  core_result;
  logic                core_step;
  logic                core_emit;
  logic                in_accept;

  // A byte moves on unless it makes a result and the result register is still full.
  assign core_step = in_valid_r && (!core_emit || !out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !core_step;
  assign in_accept = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (core_step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item_r <= in_item;
    end
  end

  // Parser core.
  lsh_core #(
    .ORIGINATOR_BITS (ORIGINATOR_BITS),
    .NUMBER_BITS     (NUMBER_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (core_step),
    .item   (in_item_r),
    .emit   (core_emit),
    .result (core_result)
  );

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (core_step && core_emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (core_step && core_emit) begin
      out_item_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// File: bench/tb_ltp_segment_header_parser.sv
// Self-checking testbench for the LTP segment header parser.
`timescale 1ns / 100ps

module tb_ltp_segment_header_parser;

  // Tracks the parser state for each accepted byte and holds the headers it must emit.
  class header_scoreboard;
    lsh_pkg::phase_t    phase      = lsh_pkg::PH_CONTROL;
    logic [63:0]        acc        = '0;
    logic [63:0]        originator = '0;
    logic [7:0]         control    = '0;
    logic [4:0]         count      = '0;
    logic               overflow   = 1'b0;
    lsh_pkg::out_item_t expected[$];
    int                 failures   = 0;

    // Shifts one 7-bit group into the SDNV accumulator at the given field width.
    function void shift_group(logic [7:0] value, int bits);
      logic [63:0] mask;
      logic [63:0] cur;
      mask = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
      cur = acc & mask;
      if (bits > lsh_pkg::GROUP_BITS) begin
        if ((cur >> (bits - lsh_pkg::GROUP_BITS)) != 64'd0) overflow = 1'b1;
      end else if (cur != 64'd0) begin
        overflow = 1'b1;
      end
      acc = ((cur << lsh_pkg::GROUP_BITS) | {57'd0, value[6:0]}) & mask;
    endfunction

    // Advances the parser by one accepted byte item.
    function void note_byte(lsh_pkg::in_item_t it);
      lsh_pkg::out_item_t hdr;
      if (it.restart) phase = lsh_pkg::PH_CONTROL;
      if (phase != lsh_pkg::PH_CONTROL && count < lsh_pkg::COUNT_MAX) count = count + 5'd1;
      case (phase)
        lsh_pkg::PH_CONTROL: begin
          control    = it.byte_value;
          acc        = '0;
          originator = '0;
          overflow   = 1'b0;
          count      = lsh_pkg::COUNT_FIRST;
          phase      = lsh_pkg::PH_ORIG;
        end
        lsh_pkg::PH_ORIG: begin
          shift_group(it.byte_value, lsh_pkg::ORIGINATOR_BITS_DEF);
          if (!it.byte_value[7]) begin
            originator = acc;
            acc        = '0;
            phase      = lsh_pkg::PH_NUM;
          end
        end
        lsh_pkg::PH_NUM: begin
          shift_group(it.byte_value, lsh_pkg::NUMBER_BITS_DEF);
          if (!it.byte_value[7]) phase = lsh_pkg::PH_EXT;
        end
        default: begin
          hdr.version           = control[7:4];
          hdr.segment_type      = control[3:0];
          hdr.originator        = originator;
          hdr.session_number    = acc[31:0];
          hdr.header_ext_count  = it.byte_value[7:4];
          hdr.trailer_ext_count = it.byte_value[3:0];
          hdr.header_length     = count;
          hdr.overflow_error    = overflow;
          expected.insert(expected.size(), hdr);
          phase      = lsh_pkg::PH_CONTROL;
          acc        = '0;
          originator = '0;
          control    = '0;
          count      = '0;
          overflow   = 1'b0;
        end
      endcase
    endfunction

    // Compares one emitted header with the oldest one still owed.
    function void check_header(lsh_pkg::out_item_t got);
      lsh_pkg::out_item_t want;
      logic               bad;
      if (expected.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected header: ver=%h type=%h orig=%h num=%h len=%0d",
                   got.version, got.segment_type, got.originator,
                   got.session_number, got.header_length);
        return;
      end
      want = expected.pop_front();
      bad = (got.version !== want.version) ||
            (got.segment_type !== want.segment_type) ||
            (got.originator !== want.originator) ||
            (got.session_number !== want.session_number) ||
            (got.header_ext_count !== want.header_ext_count) ||
            (got.trailer_ext_count !== want.trailer_ext_count) ||
            (got.header_length !== want.header_length) ||
            (got.overflow_error !== want.overflow_error);
      if (bad) begin
        failures++;
        if (failures <= 10) begin
          $display({"header mismatch, expected: ver=%h type=%h orig=%h num=%h",
                    " ext=%h/%h len=%0d ovf=%b"},
                   want.version, want.segment_type, want.originator, want.session_number,
                   want.header_ext_count, want.trailer_ext_count, want.header_length,
                   want.overflow_error);
          $display({"                 actual:   ver=%h type=%h orig=%h num=%h",
                    " ext=%h/%h len=%0d ovf=%b"},
                   got.version, got.segment_type, got.originator, got.session_number,
                   got.header_ext_count, got.trailer_ext_count, got.header_length,
                   got.overflow_error);
        end
      end
    endfunction
  endclass

  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 120;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  lsh_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  lsh_pkg::out_item_t out_item;

  header_scoreboard headers;
  logic [7:0]       hdr_bytes[$];
  int               bytes_sent = 0;
  bit               idle_on    = 1'b0;
  bit               hold_req   = 1'b0;
  bit               aligned    = 1'b1;

  ltp_segment_header_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  function automatic logic [69:0] rand_value();
    logic [31:0] r;
    r = $urandom;
    return {r[5:0], $urandom, $urandom};
  endfunction

  // Appends an SDNV of the given group count, after some leading zero groups.
  function automatic void add_sdnv(logic [69:0] val, int ngroups, int lead);
    int          i;
    logic [69:0] sh;
    for (i = 0; i < lead; i++) hdr_bytes.insert(hdr_bytes.size(), 8'h80);
    for (i = ngroups - 1; i >= 0; i--) begin
      sh = val >> (lsh_pkg::GROUP_BITS * i);
      hdr_bytes.insert(hdr_bytes.size(), {i != 0, sh[6:0]});
    end
  endfunction

  function automatic void start_header(logic [7:0] ctl);
    hdr_bytes.delete();
    hdr_bytes.insert(hdr_bytes.size(), ctl);
  endfunction

  // Offers one byte item, with an optional idle burst first, and waits for acceptance.
  task automatic send_byte(logic [7:0] value, logic rs);
    lsh_pkg::in_item_t it;
    it.byte_value = value;
    it.restart    = rs;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    headers.note_byte(it);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Sends the first keep bytes of the assembled header.
  task automatic send_header(bit rs_first, int keep);
    int i;
    for (i = 0; i < keep; i++) send_byte(hdr_bytes[i], (i == 0) ? rs_first : 1'b0);
    hdr_bytes.delete();
  endtask

  // Builds a random header; a broken one is cut short before its extensions byte.
  task automatic random_header(bit broken);
    logic [69:0] oval;
    logic [69:0] nval;
    int          og;
    int          ng;
    int          olead;
    int          nlead;
    bit          rs;
    oval  = rand_value();
    nval  = rand_value();
    og    = $urandom_range(1, 10);
    ng    = $urandom_range(1, 6);
    olead = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 1);
    nlead = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 0;
    if ($urandom_range(0, 1) != 0) oval[69:64] = '0;
    if ($urandom_range(0, 1) != 0) nval[69:32] = '0;
    start_header(rand_byte());
    add_sdnv(oval, og, olead);
    add_sdnv(nval, ng, nlead);
    hdr_bytes.insert(hdr_bytes.size(), rand_byte());
    rs = aligned ? ($urandom_range(0, 1) != 0) : 1'b1;
    if (broken) begin
      send_header(rs, $urandom_range(1, hdr_bytes.size() - 1));
      aligned = 1'b0;
    end else begin
      send_header(rs, hdr_bytes.size());
      aligned = 1'b1;
    end
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Check every accepted result.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) headers.check_header(out_item);
  end

  // Main sequence: reset, directed headers, then random traffic.
  initial begin
    int  start_count;
    int  kind;
    int  n;
    int  i;
    bit  hold_done;
    headers  = new;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    hold_done = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Shortest header with every field zero.
    start_header(8'h00);
    add_sdnv(70'd0, 1, 0);
    add_sdnv(70'd0, 1, 0);
    hdr_bytes.insert(hdr_bytes.size(), 8'h00);
    send_header(1'b0, hdr_bytes.size());

    // All-ones field values, restart raised on a control byte.
    start_header(8'hFF);
    add_sdnv({6'd0, {64{1'b1}}}, 10, 0);
    add_sdnv({38'd0, {32{1'b1}}}, 5, 0);
    hdr_bytes.insert(hdr_bytes.size(), 8'hFF);
    send_header(1'b1, hdr_bytes.size());

    // Header abandoned in the middle of the originator.
    start_header(8'h5A);
    hdr_bytes.insert(hdr_bytes.size(), 8'h81);
    send_header(1'b0, hdr_bytes.size());

    // Restart mid-header, leading zero groups, and an overflowing session number.
    start_header(8'hA5);
    add_sdnv(70'd5, 1, 2);
    add_sdnv((70'h7F << 35) | 70'h1234, 6, 0);
    hdr_bytes.insert(hdr_bytes.size(), 8'h5A);
    send_header(1'b1, hdr_bytes.size());

    // Random traffic: mostly well-formed headers, some cut short, some noise.
    start_count = bytes_sent;
    idle_on = 1'b1;
    while (bytes_sent - start_count < RANDOM_ITEMS) begin
      if (bytes_sent - start_count >= RANDOM_ITEMS - 70)
        idle_on = 1'b0;
      else if ($urandom_range(0, 9) == 0)
        idle_on = !idle_on;
      if (!hold_done && bytes_sent - start_count >= 150) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        random_header(1'b0);
      end else if (kind == 8) begin
        random_header(1'b1);
      end else begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) send_byte(rand_byte(), $urandom_range(0, 1) != 0);
        aligned = 1'b0;
      end
    end
    in_valid <= 1'b0;

    // Drain the owed headers, then give the pipeline time to show any extras.
    while (headers.expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (headers.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #200000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: ltp_segment_header_parser.f
hw/rtl/lsh_pkg.sv
hw/rtl/lsh_sdnv_step.sv
hw/rtl/lsh_core.sv
hw/rtl/ltp_segment_header_parser.sv
bench/tb_ltp_segment_header_parser.sv
